// ===== rtl/qsc_pkg.sv =====
// shared types and constants of the quadratic soft clipper
// used by every module of the block, depends on nothing
package qsc_pkg;

	// sample and channel format
	localparam int SAMPLE_BITS  = 24;
	localparam int MAX_CHANNELS = 32;
	localparam int CH_W         = 5;
	localparam int MASK_W       = 32;

	// parameter formats: levels are unsigned Q0.23, gain unsigned Q3.15
	localparam int LEVEL_W = 23;
	localparam int GAIN_W  = 18;
	localparam int CFG_W   = LEVEL_W;
	localparam int IDX_W   = 3;

	// magnitude compare width covers both the sample magnitude and a level
	localparam int CMP_W = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

	// product path: gain * excess, then * excess again
	localparam int PROD1_W    = GAIN_W + LEVEL_W;
	localparam int PROD_W     = PROD1_W + LEVEL_W;
	localparam int PROD_SHIFT = 38;
	localparam int SUB_W      = PROD_W - PROD_SHIFT;
	localparam int DIFF_W     = SUB_W + 1;

	// saturation width holds the difference magnitude and the sample limit
	localparam int RES_W = ((SUB_W > SAMPLE_BITS) ? SUB_W : SAMPLE_BITS) + 1;
	localparam logic [RES_W-1:0] SAT_NEG = RES_W'(1) << (SAMPLE_BITS - 1);
	localparam logic [RES_W-1:0] SAT_POS = SAT_NEG - RES_W'(1);

	// stream word widths, padded to whole bytes
	localparam int IN_DATA_W  = ((SAMPLE_BITS + CH_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((SAMPLE_BITS + MASK_W + 7) / 8) * 8;

	// register reset values
	localparam logic [LEVEL_W-1:0] KNEE_RST = LEVEL_W'(2726298);
	localparam logic [LEVEL_W-1:0] CEIL_RST = LEVEL_W'(5662310);
	localparam logic [GAIN_W-1:0]  GAIN_RST = GAIN_W'(46811);

	// register map
	typedef enum logic [IDX_W-1:0] {
		REG_KNEE_HIGH = 3'd0,
		REG_CEIL_HIGH = 3'd1,
		REG_GAIN_HIGH = 3'd2,
		REG_KNEE_LOW  = 3'd3,
		REG_CEIL_LOW  = 3'd4,
		REG_GAIN_LOW  = 3'd5,
		REG_SET_SEL   = 3'd6,
		REG_BYPASS    = 3'd7
	} reg_idx_t;

	// parameter set in use
	typedef struct packed {
		logic [LEVEL_W-1:0] knee;
		logic [LEVEL_W-1:0] ceil;
		logic [GAIN_W-1:0]  gain;
		logic               bypass;
	} params_t;

	// controller commands to the datapath
	typedef struct packed {
		logic accept;
		logic mul1;
		logic mul2;
		logic out_load;
	} cmd_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_MUL1 = 2'd1,
		ST_MUL2 = 2'd2
	} state_t;

endpackage

// ===== rtl/qsc_cfg.sv =====
// configuration register bank of the soft clipper
// holds both parameter sets and selects the one in use; uses qsc_pkg
module qsc_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [qsc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [qsc_pkg::CFG_W-1:0]    cfg_data,
	output qsc_pkg::params_t             params
);
	import qsc_pkg::*;

	logic [LEVEL_W-1:0] knee_high_q, ceil_high_q, knee_low_q, ceil_low_q;
	logic [GAIN_W-1:0]  gain_high_q, gain_low_q;
	logic               set_sel_q, bypass_q;

	// register writes, values cut to their widths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knee_high_q <= KNEE_RST;
			ceil_high_q <= CEIL_RST;
			gain_high_q <= GAIN_RST;
			knee_low_q  <= KNEE_RST;
			ceil_low_q  <= CEIL_RST;
			gain_low_q  <= GAIN_RST;
			set_sel_q   <= 1'b1;
			bypass_q    <= 1'b0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_KNEE_HIGH: knee_high_q <= cfg_data[LEVEL_W-1:0];
				REG_CEIL_HIGH: ceil_high_q <= cfg_data[LEVEL_W-1:0];
				REG_GAIN_HIGH: gain_high_q <= cfg_data[GAIN_W-1:0];
				REG_KNEE_LOW:  knee_low_q  <= cfg_data[LEVEL_W-1:0];
				REG_CEIL_LOW:  ceil_low_q  <= cfg_data[LEVEL_W-1:0];
				REG_GAIN_LOW:  gain_low_q  <= cfg_data[GAIN_W-1:0];
				REG_SET_SEL:   set_sel_q   <= cfg_data[0];
				REG_BYPASS:    bypass_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// parameter set selection
	always_comb begin
		params.knee   = set_sel_q ? knee_high_q : knee_low_q;
		params.ceil   = set_sel_q ? ceil_high_q : ceil_low_q;
		params.gain   = set_sel_q ? gain_high_q : gain_low_q;
		params.bypass = bypass_q;
	end

endmodule

// ===== rtl/qsc_ctrl.sv =====
// sequencing controller of the soft clipper
// steps the shared multiplier and owns the stage valid flags; uses qsc_pkg
module qsc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output qsc_pkg::cmd_t cmd
);
	import qsc_pkg::*;

	state_t state_q, state_d;
	logic   s2_valid_q, out_valid_q;
	logic   out_load, s2_free;

	// output register loads when the finishing stage holds a word and room is there
	assign out_load = s2_valid_q && (!out_valid_q || m_tready);
	assign s2_free  = !s2_valid_q || out_load;
	assign m_tvalid = out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		cmd.accept   = 1'b0;
		cmd.mul1     = 1'b0;
		cmd.mul2     = 1'b0;
		cmd.out_load = out_load;
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				// the next word enters while this one moves to the finishing stage
				s_tready   = s2_free;
				cmd.mul2   = s2_free;
				cmd.accept = s_tvalid && s2_free;
				if (s2_free) begin
					state_d = s_tvalid ? ST_MUL1 : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.mul2) begin
				s2_valid_q <= 1'b1;
			end else if (out_load) begin
				s2_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/qsc_datapath.sv =====
// datapath of the soft clipper: front end, shared multiplier, finishing stage
// and activity mask registers; driven by qsc_ctrl commands, uses qsc_pkg
module qsc_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  qsc_pkg::cmd_t                     cmd,
	input  qsc_pkg::params_t                  params,
	input  logic [qsc_pkg::SAMPLE_BITS-1:0]   sample_in,
	input  logic [qsc_pkg::CH_W-1:0]          channel_index,
	input  logic                              block_last,
	output logic [qsc_pkg::SAMPLE_BITS-1:0]   sample_out,
	output logic                              mask_valid,
	output logic [qsc_pkg::MASK_W-1:0]        activity_mask
);
	import qsc_pkg::*;

	// front end signals
	logic [SAMPLE_BITS-1:0] mag;
	logic [CMP_W-1:0]       mag_e, ceil_e, knee_e;
	logic [LEVEL_W-1:0]     lim, ex;
	logic                   hit;
	logic [MASK_W-1:0]      hit_vec, acc_next;
	logic [MASK_W-1:0]      acc_q, pub_q;

	// front end registers
	logic [SAMPLE_BITS-1:0] x_s1;
	logic                   neg_s1, byp_s1, last_s1;
	logic [LEVEL_W-1:0]     lim_s1, ex_s1;
	logic [MASK_W-1:0]      mask_s1;

	// multiplier
	logic [PROD1_W-1:0]     mul_a, p1_q;
	logic [PROD_W-1:0]      mul_p;

	// finishing stage registers
	logic [PROD_W-1:0]      p2_s2;
	logic [SAMPLE_BITS-1:0] x_s2;
	logic                   neg_s2, byp_s2, last_s2;
	logic [LEVEL_W-1:0]     lim_s2;
	logic [MASK_W-1:0]      mask_s2;

	// finishing logic
	logic [SUB_W-1:0]       sub;
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]      diff_mag;
	logic [RES_W-1:0]       m_e;
	logic [SAMPLE_BITS-1:0] y;

	// output register
	logic [SAMPLE_BITS-1:0] out_sample_q;
	logic                   out_last_q;
	logic [MASK_W-1:0]      out_mask_q;

	// magnitude, limit, excess over the knee and activity hit
	always_comb begin
		mag      = sample_in[SAMPLE_BITS-1] ? (~sample_in + SAMPLE_BITS'(1)) : sample_in;
		mag_e    = CMP_W'(mag);
		ceil_e   = CMP_W'(params.ceil);
		knee_e   = CMP_W'(params.knee);
		lim      = (mag_e < ceil_e) ? mag_e[LEVEL_W-1:0] : params.ceil;
		ex       = (lim > params.knee) ? (lim - params.knee) : '0;
		hit      = !params.bypass && (mag_e > knee_e) && (32'(channel_index) < MAX_CHANNELS);
		hit_vec  = hit ? (MASK_W'(1) << channel_index) : '0;
		acc_next = acc_q | hit_vec;
	end

	// activity accumulator and published mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			pub_q <= '0;
		end else if (cmd.accept) begin
			if (block_last) begin
				pub_q <= acc_next;
				acc_q <= '0;
			end else begin
				acc_q <= acc_next;
			end
		end
	end

	// front end capture of an accepted word
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_s1    <= sample_in;
			neg_s1  <= sample_in[SAMPLE_BITS-1];
			byp_s1  <= params.bypass;
			last_s1 <= block_last;
			lim_s1  <= lim;
			ex_s1   <= ex;
			mask_s1 <= block_last ? acc_next : pub_q;
		end
	end

	// shared multiplier: gain times excess, then that times excess
	assign mul_a = cmd.mul2 ? p1_q : PROD1_W'(params.gain);
	assign mul_p = PROD_W'(mul_a) * PROD_W'(ex_s1);

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			p1_q <= mul_p[PROD1_W-1:0];
		end
	end

	// hand over to the finishing stage
	always_ff @(posedge clk) begin
		if (cmd.mul2) begin
			p2_s2   <= mul_p;
			x_s2    <= x_s1;
			neg_s2  <= neg_s1;
			byp_s2  <= byp_s1;
			last_s2 <= last_s1;
			lim_s2  <= lim_s1;
			mask_s2 <= mask_s1;
		end
	end

	// round half up, subtract from the limited level, restore sign, saturate; bypass passes the sample
	always_comb begin
		sub      = p2_s2[PROD_W-1:PROD_SHIFT] + SUB_W'(p2_s2[PROD_SHIFT-1]);
		diff     = $signed(DIFF_W'(lim_s2)) - $signed(DIFF_W'(sub));
		diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		m_e      = RES_W'(diff_mag);
		if (byp_s2) begin
			y = x_s2;
		end else if (neg_s2) begin
			if (m_e >= SAT_NEG) begin
				y = SAT_NEG[SAMPLE_BITS-1:0];
			end else begin
				y = ~m_e[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1);
			end
		end else begin
			if (m_e > SAT_POS) begin
				y = SAT_POS[SAMPLE_BITS-1:0];
			end else begin
				y = m_e[SAMPLE_BITS-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_sample_q <= y;
			out_last_q   <= last_s2;
			out_mask_q   <= mask_s2;
		end
	end

	assign sample_out    = out_sample_q;
	assign mask_valid    = out_last_q;
	assign activity_mask = out_mask_q;

endmodule

// ===== rtl/quadratic_soft_clipper_multichannel.sv =====
// quadratic knee soft clipper with per block channel activity mask
// a result word passes the front end, first product, finishing stage and output registers
// the single multiplier forms gain * excess and then * excess again; the next word is
// taken as one leaves the multiplier, unless output back-pressure holds the finishing stage
// reset (asynchronous, active low): registers to defaults, masks cleared, no word held
module quadratic_soft_clipper_multichannel (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// sample_in [23:0], channel_index [28:24], zero pad
	input  logic [qsc_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic                              s_tlast,
	// output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// sample_out [23:0], activity_mask [55:24]
	output logic [qsc_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              m_tlast,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [qsc_pkg::IDX_W-1:0]         cfg_index,
	input  logic [qsc_pkg::CFG_W-1:0]         cfg_data
);
	import qsc_pkg::*;

	params_t                params;
	cmd_t                   cmd;
	logic [SAMPLE_BITS-1:0] sample_out;
	logic [MASK_W-1:0]      activity_mask;

	// configuration registers
	qsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.params    (params)
	);

	// controller
	qsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// datapath
	qsc_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.params        (params),
		.sample_in     (s_tdata[SAMPLE_BITS-1:0]),
		.channel_index (s_tdata[SAMPLE_BITS +: CH_W]),
		.block_last    (s_tlast),
		.sample_out    (sample_out),
		.mask_valid    (m_tlast),
		.activity_mask (activity_mask)
	);

	// pack the output word
	assign m_tdata = OUT_DATA_W'({activity_mask, sample_out});

endmodule

// ===== test/tb_quadratic_soft_clipper_multichannel.sv =====
// testbench of the quadratic knee soft clipper: directed and random words checked
// against a predictor of the clip arithmetic and the per block activity mask
// depends on qsc_pkg and quadratic_soft_clipper_multichannel
`timescale 1ns / 100ps

module tb_quadratic_soft_clipper_multichannel;
	import qsc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
	localparam logic [GAIN_W-1:0]  GAIN_MAX  = '1;

	// expected output word
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] smp;
		logic                   last;
		logic [MASK_W-1:0]      mask;
	} clip_word_t;

	logic                     clk;
	logic                     arst_n    = 1'b0;
	logic                     s_tvalid  = 1'b0;
	logic                     s_tready;
	// sample_in [23:0], channel_index [28:24], zero pad
	logic [IN_DATA_W-1:0]     s_tdata   = '0;
	logic                     s_tlast   = 1'b0;
	logic                     m_tvalid;
	logic                     m_tready  = 1'b1;
	// sample_out [23:0], activity_mask [55:24]
	logic [OUT_DATA_W-1:0]    m_tdata;
	logic                     m_tlast;
	logic                     cfg_we    = 1'b0;
	logic [IDX_W-1:0]         cfg_index = '0;
	logic [CFG_W-1:0]         cfg_data  = '0;

	// predictor copy of the registers, index 1 is the high set
	logic [LEVEL_W-1:0] knee_reg [2] = '{KNEE_RST, KNEE_RST};
	logic [LEVEL_W-1:0] ceil_reg [2] = '{CEIL_RST, CEIL_RST};
	logic [GAIN_W-1:0]  gain_reg [2] = '{GAIN_RST, GAIN_RST};
	logic               set_sel      = 1'b1;
	logic               byp          = 1'b0;
	logic [MASK_W-1:0]  mask_acc     = '0;
	logic [MASK_W-1:0]  mask_pub     = '0;

	clip_word_t pending_words[$];
	int         errors   = 0;
	int         cycles   = 0;
	bit         gaps_on  = 1'b1;

	quadratic_soft_clipper_multichannel dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock; the single reset is released in the test sequence
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// clip arithmetic: limit, quadratic knee, sign restore, saturation
	function automatic logic [SAMPLE_BITS-1:0] clip_sample(logic [SAMPLE_BITS-1:0] smp,
			logic [LEVEL_W-1:0] knee, logic [LEVEL_W-1:0] ceil, logic [GAIN_W-1:0] gain);
		logic [SAMPLE_BITS-1:0] mag;
		logic [LEVEL_W-1:0]     lim;
		logic [LEVEL_W-1:0]     ex;
		logic [64:0]            prod;
		logic [26:0]            sub;
		logic [26:0]            diff;
		logic [SAMPLE_BITS-1:0] res;
		mag  = smp[SAMPLE_BITS-1] ? SAMPLE_BITS'(-smp) : smp;
		lim  = (mag < {1'b0, ceil}) ? mag[LEVEL_W-1:0] : ceil;
		ex   = (lim > knee) ? lim - knee : '0;
		prod = 65'(ex) * 65'(ex) * 65'(gain) + (65'd1 << 37);
		sub  = 27'(prod >> 38);
		diff = ({4'd0, lim} >= sub) ? {4'd0, lim} - sub : sub - {4'd0, lim};
		if (diff > 27'h800000)
			diff = 27'h800000;
		if (smp[SAMPLE_BITS-1])
			res = SAMPLE_BITS'(-diff);
		else
			res = (diff > 27'h7FFFFF) ? 24'h7FFFFF : diff[SAMPLE_BITS-1:0];
		return res;
	endfunction

	// expected word for one accepted input, advances the mask state
	function automatic clip_word_t predict_word(logic [SAMPLE_BITS-1:0] smp,
			logic [CH_W-1:0] ch, logic last);
		clip_word_t             w;
		logic [SAMPLE_BITS-1:0] mag;
		mag = smp[SAMPLE_BITS-1] ? SAMPLE_BITS'(-smp) : smp;
		if (byp) begin
			w.smp = smp;
		end else begin
			w.smp = clip_sample(smp, knee_reg[set_sel], ceil_reg[set_sel], gain_reg[set_sel]);
			if (mag > {1'b0, knee_reg[set_sel]} && ch < MAX_CHANNELS)
				mask_acc[ch] = 1'b1;
		end
		w.last = last;
		if (last) begin
			mask_pub = mask_acc;
			mask_acc = '0;
		end
		w.mask = mask_pub;
		return w;
	endfunction

	// send one word, at times with a random gap in front of it
	task automatic send_word(logic [SAMPLE_BITS-1:0] smp, logic [CH_W-1:0] ch, logic last);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_DATA_W'({ch, smp});
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_words.push_back(predict_word(smp, ch, last));
	endtask

	// register write once the block has drained
	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
		s_tvalid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_KNEE_HIGH: knee_reg[1] = val[LEVEL_W-1:0];
			REG_CEIL_HIGH: ceil_reg[1] = val[LEVEL_W-1:0];
			REG_GAIN_HIGH: gain_reg[1] = val[GAIN_W-1:0];
			REG_KNEE_LOW:  knee_reg[0] = val[LEVEL_W-1:0];
			REG_CEIL_LOW:  ceil_reg[0] = val[LEVEL_W-1:0];
			REG_GAIN_LOW:  gain_reg[0] = val[GAIN_W-1:0];
			REG_SET_SEL:   set_sel     = val[0];
			REG_BYPASS:    byp         = val[0];
			default: ;
		endcase
	endtask

	// writes one full parameter set and selects it
	task automatic load_set(logic sel, logic [LEVEL_W-1:0] knee, logic [LEVEL_W-1:0] ceil,
			logic [GAIN_W-1:0] gain);
		write_reg(reg_idx_t'(sel ? REG_KNEE_HIGH : REG_KNEE_LOW), knee);
		write_reg(reg_idx_t'(sel ? REG_CEIL_HIGH : REG_CEIL_LOW), ceil);
		write_reg(reg_idx_t'(sel ? REG_GAIN_HIGH : REG_GAIN_LOW), {5'($urandom), gain});
		write_reg(REG_SET_SEL, {22'($urandom), sel});
	endtask

	// level register value, extremes now and then
	function automatic logic [LEVEL_W-1:0] pick_level();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return LEVEL_MAX;
			default: return LEVEL_W'($urandom);
		endcase
	endfunction

	// sample around or between the knee and ceiling of the set in use, a full scale or near zero extreme, or anywhere
	function automatic logic [SAMPLE_BITS-1:0] pick_sample(logic [LEVEL_W-1:0] knee,
			logic [LEVEL_W-1:0] ceil);
		logic [SAMPLE_BITS-1:0] mag;
		case ($urandom_range(0, 5))
			0, 1: return SAMPLE_BITS'($urandom);
			2: mag = {1'b0, knee} + SAMPLE_BITS'($urandom_range(0, 4)) - 24'd2;
			3: mag = {1'b0, ceil} + SAMPLE_BITS'($urandom_range(0, 4)) - 24'd2;
			4: begin
				case ($urandom_range(0, 4))
					0:       return 24'h800000;
					1:       return 24'h7FFFFF;
					2:       return 24'h000000;
					3:       return 24'hFFFFFF;
					default: return 24'h000001;
				endcase
			end
			default: mag = SAMPLE_BITS'($urandom_range(knee, ceil));
		endcase
		return $urandom_range(0, 1) ? SAMPLE_BITS'(-mag) : mag;
	endfunction

	// reset settings: zero, unit steps, knee and ceiling edges, full scale
	task automatic test_reset_settings();
		send_word(24'd0, 5'd0, 1'b0);
		send_word(24'd1, 5'd1, 1'b0);
		send_word(24'hFFFFFF, 5'd2, 1'b0);
		send_word(24'(KNEE_RST), 5'd3, 1'b0);
		send_word(24'(KNEE_RST) + 24'd1, 5'd4, 1'b0);
		send_word(-(24'(KNEE_RST) + 24'd1), 5'd5, 1'b0);
		send_word(24'(CEIL_RST), 5'd6, 1'b0);
		send_word(24'(CEIL_RST) + 24'd1, 5'd7, 1'b0);
		send_word(24'h7FFFFF, 5'd30, 1'b0);
		send_word(24'h800000, 5'd31, 1'b1);
		send_word(24'h555555, 5'd10, 1'b0);
		send_word(24'hAAAAAA, 5'd21, 1'b1);
	endtask

	// zero knee, full gain: negative difference and output saturation
	task automatic test_clip_extremes();
		load_set(1'b0, '0, LEVEL_MAX, GAIN_MAX);
		send_word(24'h7FFFFF, 5'd0, 1'b0);
		send_word(24'h800000, 5'd1, 1'b0);
		send_word(24'd100, 5'd2, 1'b0);
		send_word(24'd3000000, 5'd3, 1'b0);
		send_word(-24'd3000000, 5'd4, 1'b1);
	endtask

	// knee set above the ceiling: output is the limited sample
	task automatic test_knee_above_ceiling();
		load_set(1'b1, LEVEL_MAX, 23'd1000, GAIN_MAX);
		send_word(24'h7FFFFF, 5'd8, 1'b0);
		send_word(24'hFFFFFB, 5'd9, 1'b0);
		send_word(24'h800000, 5'd17, 1'b1);
	endtask

	// bypass passes samples and leaves the mask empty
	task automatic test_bypass();
		write_reg(REG_BYPASS, {22'($urandom), 1'b1});
		send_word(24'h7FFFFF, 5'd9, 1'b0);
		send_word(24'h800000, 5'd9, 1'b1);
		send_word(24'd12345, 5'd3, 1'b1);
	endtask

	// fixed extreme or random settings, then blocks of interleaved channels
	task automatic test_random_traffic(int phase, int count);
		int               left;
		int               nch;
		int               base;
		int               pos;
		logic [CH_W-1:0]  ch;
		case (phase)
			0:       load_set(1'b0, '0, LEVEL_MAX, GAIN_MAX);
			1:       load_set(1'b1, LEVEL_MAX, LEVEL_MAX, '0);
			default: load_set(1'($urandom), pick_level(), pick_level(),
					($urandom_range(0, 3) == 0) ? GAIN_MAX : GAIN_W'($urandom));
		endcase
		write_reg(reg_idx_t'(set_sel ? REG_KNEE_LOW : REG_KNEE_HIGH), pick_level());
		write_reg(REG_BYPASS, {22'($urandom), 1'(phase == 3 || $urandom_range(0, 5) == 0)});
		left = 0;
		nch  = 1;
		base = 0;
		pos  = 0;
		for (int i = 0; i < count; i++) begin
			if (left == 0) begin
				left = $urandom_range(1, 24);
				nch  = $urandom_range(1, 32);
				base = $urandom_range(0, 31);
				pos  = 0;
			end
			if ($urandom_range(0, 7) == 0)
				ch = CH_W'($urandom);
			else
				ch = CH_W'(base + pos % nch);
			left--;
			pos++;
			send_word(pick_sample(knee_reg[set_sel], ceil_reg[set_sel]), ch,
				left == 0 || $urandom_range(0, 31) == 0);
		end
	endtask

	// receiver stalls in random bursts
	initial begin
		forever begin
			@(posedge clk);
			if (gaps_on && arst_n && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	// compare each output word with the oldest expectation
	always @(posedge clk) begin
		clip_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_words.size() == 0) begin
				$error("output word with nothing expected: tdata %h tlast %b", m_tdata, m_tlast);
				errors++;
			end else begin
				want = pending_words.pop_front();
				if (m_tdata[SAMPLE_BITS-1:0] !== want.smp) begin
					$error("sample_out expected %h actual %h", want.smp,
						m_tdata[SAMPLE_BITS-1:0]);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("mask_valid expected %b actual %b", want.last, m_tlast);
					errors++;
				end
				if (m_tdata[SAMPLE_BITS+MASK_W-1:SAMPLE_BITS] !== want.mask) begin
					$error("activity_mask expected %h actual %h", want.mask,
						m_tdata[SAMPLE_BITS+MASK_W-1:SAMPLE_BITS]);
					errors++;
				end
			end
		end
	end

	// run time limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// test sequence
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_settings();
		test_clip_extremes();
		test_knee_above_ceiling();
		test_bypass();
		for (int p = 0; p < 8; p++) begin
			gaps_on = (p < 7);
			test_random_traffic(p, 144);
		end
		s_tvalid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/qsc_pkg.sv
rtl/qsc_cfg.sv
rtl/qsc_ctrl.sv
rtl/qsc_datapath.sv
rtl/quadratic_soft_clipper_multichannel.sv
test/tb_quadratic_soft_clipper_multichannel.sv
